// ===== sv/rtfd_pkg.sv =====
`default_nettype none

package rtfd_pkg;

    // Register map: index of each configuration register
    localparam logic [1:0] REG_BPP   = 2'd0;
    localparam logic [1:0] REG_LINE  = 2'd1;
    localparam logic [1:0] REG_FRAME = 2'd2;

    // Reset values of the configuration registers
    localparam logic [2:0]  RST_BPP   = 3'd3;
    localparam logic [12:0] RST_LINE  = 13'd640;
    localparam logic [24:0] RST_FRAME = 25'd921600;

    // End status codes of a finish word
    localparam logic [1:0] ST_EXHAUSTED = 2'd0;
    localparam logic [1:0] ST_EOB       = 2'd1;
    localparam logic [1:0] ST_BOUNDS    = 2'd2;

    // Result word kinds
    localparam logic KIND_SPAN   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // Parser phases
    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_ESCAPE,
        PH_RUN,
        PH_DX,
        PH_DY,
        PH_LIT
    } t_phase;

    // Input word
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        start_of_chunk;
        logic [24:0] chunk_length;
    } t_in;

    // Result word
    typedef struct packed {
        logic        kind;
        logic [23:0] write_offset;
        logic [7:0]  pixel_count;
        logic [31:0] pixel_value;
        logic [1:0]  end_status;
    } t_out;

    // Configuration as seen by the parser
    typedef struct packed {
        logic [2:0]  pix_bytes;
        logic [12:0] line_pixels;
        logic [24:0] frame_bytes;
    } t_cfg;

    // Results of one parsed byte: an optional span, then an optional finish
    typedef struct packed {
        logic       span_vld;
        t_out       span;
        logic       fin_vld;
        logic [1:0] fin_status;
    } t_push;

endpackage

`default_nettype wire

// ===== sv/rtfd_cfg.sv =====
`default_nettype none

module rtfd_cfg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output rtfd_pkg::t_cfg          o_cfg
);

    logic [2:0]  r_bpp;
    logic [12:0] r_line;
    logic [24:0] r_frame;
    logic [1:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp   <= rtfd_pkg::RST_BPP;
            r_line  <= rtfd_pkg::RST_LINE;
            r_frame <= rtfd_pkg::RST_FRAME;
        end else if (wr_en) begin
            unique case (reg_idx)
                rtfd_pkg::REG_BPP:   r_bpp   <= pwdata[2:0];
                rtfd_pkg::REG_LINE:  r_line  <= pwdata[12:0];
                rtfd_pkg::REG_FRAME: r_frame <= pwdata[24:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            rtfd_pkg::REG_BPP:   prdata = {29'd0, r_bpp};
            rtfd_pkg::REG_LINE:  prdata = {19'd0, r_line};
            rtfd_pkg::REG_FRAME: prdata = {7'd0, r_frame};
            default:             prdata = 32'd0;
        endcase
    end

    assign o_cfg.pix_bytes   = r_bpp;
    assign o_cfg.line_pixels = r_line;
    assign o_cfg.frame_bytes = r_frame;

endmodule

`default_nettype wire

// ===== sv/rtfd_parse.sv =====
`default_nettype none

module rtfd_parse #(
    parameter int unsigned MAX_LINE_PIXELS = 4096,
    parameter int unsigned MAX_FRAME_BYTES = 16777216
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rtfd_pkg::t_cfg     i_cfg,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire rtfd_pkg::t_in      i_in_data,
    input  wire logic               i_room,
    output rtfd_pkg::t_push         o_push
);

    localparam logic [26:0] POS_MAX = {27{1'b1}};

    function automatic logic [26:0] sat27(input logic [28:0] v);
        sat27 = (v > 29'(POS_MAX)) ? POS_MAX : v[26:0];
    endfunction

    // Input register
    logic           r_in_vld;
    rtfd_pkg::t_in  r_in;
    logic           accept;
    logic           proc;

    // Parser state
    rtfd_pkg::t_phase r_phase, n_phase, c_phase;
    logic [24:0] r_rd, n_rd, c_rd;
    logic [24:0] r_len, n_len, c_len;
    logic [26:0] r_out, n_out, c_out;
    logic [26:0] r_nlp, n_nlp, c_nlp;
    logic [7:0]  r_cnt, n_cnt, c_cnt;
    logic [31:0] r_acc, n_acc, c_acc;
    logic [1:0]  r_pbi, n_pbi, c_pbi;
    logic [7:0]  r_dx, n_dx, c_dx;
    logic        r_halted, n_halted, c_halted;
    logic [1:0]  r_code, n_code, c_code;

    // Derived configuration
    logic        bpp4;
    logic [2:0]  bpp;
    logic [12:0] eff_line;
    logic [24:0] eff_frame;
    logic [14:0] line_bytes;

    // Per-byte arithmetic
    logic [7:0]  b;
    logic [9:0]  b_bpp;
    logic [9:0]  cnt_bpp;
    logic [9:0]  dx_bpp;
    logic [22:0] dy_prod;
    logic [24:0] after;
    logic        in_chunk;
    logic [31:0] acc_new;
    logic        pix_done;
    logic [27:0] out_plus_b;

    assign accept     = i_in_valid & o_in_ready;
    assign proc       = r_in_vld & i_room;
    assign o_in_ready = ~r_in_vld | i_room;

    assign bpp4 = (i_cfg.pix_bytes == 3'd4);
    assign bpp  = bpp4 ? 3'd4 : 3'd3;

    // Clamp line width and frame size to their build limits
    assign eff_line  = (32'(i_cfg.line_pixels) > MAX_LINE_PIXELS) ?
                       13'(MAX_LINE_PIXELS) : i_cfg.line_pixels;
    assign eff_frame = (32'(i_cfg.frame_bytes) > MAX_FRAME_BYTES) ?
                       25'(MAX_FRAME_BYTES) : i_cfg.frame_bytes;
    assign line_bytes = bpp4 ? {eff_line, 2'b00}
                             : ({1'b0, eff_line, 1'b0} + {2'b00, eff_line});

    // Scaling by 3 or 4 bytes per pixel is a shift and an add
    assign b       = r_in.data_byte;
    assign b_bpp   = bpp4 ? {b, 2'b00} : ({1'b0, b, 1'b0} + {2'b00, b});
    assign cnt_bpp = bpp4 ? {r_cnt, 2'b00} : ({1'b0, r_cnt, 1'b0} + {2'b00, r_cnt});
    assign dx_bpp  = bpp4 ? {r_dx, 2'b00} : ({1'b0, r_dx, 1'b0} + {2'b00, r_dx});
    assign dy_prod = 23'(b) * 23'(line_bytes);

    // Chunk start clears positions before the byte is parsed
    always_comb begin
        if (r_in.start_of_chunk) begin
            c_phase  = rtfd_pkg::PH_OPCODE;
            c_rd     = 25'd0;
            c_len    = r_in.chunk_length;
            c_out    = 27'd0;
            c_nlp    = 27'(line_bytes);
            c_cnt    = 8'd0;
            c_acc    = 32'd0;
            c_pbi    = 2'd0;
            c_dx     = 8'd0;
            c_halted = 1'b0;
            c_code   = rtfd_pkg::ST_EXHAUSTED;
        end else begin
            c_phase  = r_phase;
            c_rd     = r_rd;
            c_len    = r_len;
            c_out    = r_out;
            c_nlp    = r_nlp;
            c_cnt    = r_cnt;
            c_acc    = r_acc;
            c_pbi    = r_pbi;
            c_dx     = r_dx;
            c_halted = r_halted;
            c_code   = r_code;
        end
    end

    assign in_chunk   = (c_rd < c_len);
    assign after      = c_len - c_rd - 25'd1;
    assign acc_new    = c_acc | (32'(b) << {c_pbi, 3'b000});
    assign pix_done   = (({1'b0, c_pbi} + 3'd1) == bpp);
    assign out_plus_b = {1'b0, c_out} + 28'(b_bpp);

    // Byte parser: next state and pushed results
    always_comb begin
        n_phase  = r_phase;
        n_rd     = r_rd;
        n_len    = r_len;
        n_out    = r_out;
        n_nlp    = r_nlp;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_pbi    = r_pbi;
        n_dx     = r_dx;
        n_halted = r_halted;
        n_code   = r_code;
        o_push   = '0;

        if (proc) begin
            n_phase  = c_phase;
            n_rd     = c_rd;
            n_len    = c_len;
            n_out    = c_out;
            n_nlp    = c_nlp;
            n_cnt    = c_cnt;
            n_acc    = c_acc;
            n_pbi    = c_pbi;
            n_dx     = c_dx;
            n_halted = c_halted;
            n_code   = c_code;

            if (in_chunk) begin
                if (!c_halted) begin
                    unique case (c_phase)
                        rtfd_pkg::PH_OPCODE: begin
                            if (c_out >= 27'(eff_frame) || after == 25'd0) begin
                                n_halted = 1'b1;
                                n_code   = rtfd_pkg::ST_BOUNDS;
                            end else if (b == 8'd0) begin
                                n_phase = rtfd_pkg::PH_ESCAPE;
                            end else if (after < 25'(bpp) ||
                                         out_plus_b > 28'(eff_frame)) begin
                                n_halted = 1'b1;
                                n_code   = rtfd_pkg::ST_BOUNDS;
                            end else begin
                                n_cnt   = b;
                                n_acc   = 32'd0;
                                n_pbi   = 2'd0;
                                n_phase = rtfd_pkg::PH_RUN;
                            end
                        end
                        rtfd_pkg::PH_ESCAPE: begin
                            if (b == 8'd0) begin
                                // end of line
                                n_out   = c_nlp;
                                n_nlp   = sat27(29'(c_nlp) + 29'(line_bytes));
                                n_phase = rtfd_pkg::PH_OPCODE;
                            end else if (b == 8'd1) begin
                                n_halted = 1'b1;
                                n_code   = rtfd_pkg::ST_EOB;
                            end else if (b == 8'd2) begin
                                if (after < 25'd2) begin
                                    n_halted = 1'b1;
                                    n_code   = rtfd_pkg::ST_BOUNDS;
                                end else begin
                                    n_phase = rtfd_pkg::PH_DX;
                                end
                            end else if (after < 25'(b_bpp) ||
                                         out_plus_b > 28'(eff_frame)) begin
                                n_halted = 1'b1;
                                n_code   = rtfd_pkg::ST_BOUNDS;
                            end else begin
                                n_cnt   = b;
                                n_acc   = 32'd0;
                                n_pbi   = 2'd0;
                                n_phase = rtfd_pkg::PH_LIT;
                            end
                        end
                        rtfd_pkg::PH_RUN: begin
                            n_acc = acc_new;
                            n_pbi = c_pbi + 2'd1;
                            if (pix_done) begin
                                o_push.span_vld          = 1'b1;
                                o_push.span.kind         = rtfd_pkg::KIND_SPAN;
                                o_push.span.write_offset = c_out[23:0];
                                o_push.span.pixel_count  = c_cnt;
                                o_push.span.pixel_value  = acc_new;
                                o_push.span.end_status   = rtfd_pkg::ST_EXHAUSTED;
                                n_out   = sat27(29'(c_out) + 29'(cnt_bpp));
                                n_phase = rtfd_pkg::PH_OPCODE;
                            end
                        end
                        rtfd_pkg::PH_DX: begin
                            n_dx    = b;
                            n_phase = rtfd_pkg::PH_DY;
                        end
                        rtfd_pkg::PH_DY: begin
                            n_out   = sat27(29'(c_out) + 29'(dx_bpp) + 29'(dy_prod));
                            n_nlp   = sat27(29'(c_nlp) + 29'(dy_prod));
                            n_phase = rtfd_pkg::PH_OPCODE;
                        end
                        rtfd_pkg::PH_LIT: begin
                            n_acc = acc_new;
                            n_pbi = c_pbi + 2'd1;
                            if (pix_done) begin
                                o_push.span_vld          = 1'b1;
                                o_push.span.kind         = rtfd_pkg::KIND_SPAN;
                                o_push.span.write_offset = c_out[23:0];
                                o_push.span.pixel_count  = 8'd1;
                                o_push.span.pixel_value  = acc_new;
                                o_push.span.end_status   = rtfd_pkg::ST_EXHAUSTED;
                                n_out = sat27(29'(c_out) + 29'(bpp));
                                n_acc = 32'd0;
                                n_pbi = 2'd0;
                                n_cnt = c_cnt - 8'd1;
                                if (c_cnt == 8'd1) begin
                                    n_phase = rtfd_pkg::PH_OPCODE;
                                end
                            end
                        end
                        default: n_phase = rtfd_pkg::PH_OPCODE;
                    endcase
                end

                // Finish word on the chunk's last byte
                if (after == 25'd0) begin
                    o_push.fin_vld    = 1'b1;
                    o_push.fin_status = n_halted ? n_code : rtfd_pkg::ST_EXHAUSTED;
                end
                n_rd = c_rd + 25'd1;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (proc) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    // Parser state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= rtfd_pkg::PH_OPCODE;
            r_rd     <= 25'd0;
            r_len    <= 25'd0;
            r_out    <= 27'd0;
            r_nlp    <= 27'(line_bytes);
            r_cnt    <= 8'd0;
            r_acc    <= 32'd0;
            r_pbi    <= 2'd0;
            r_dx     <= 8'd0;
            r_halted <= 1'b0;
            r_code   <= rtfd_pkg::ST_EXHAUSTED;
        end else begin
            r_phase  <= n_phase;
            r_rd     <= n_rd;
            r_len    <= n_len;
            r_out    <= n_out;
            r_nlp    <= n_nlp;
            r_cnt    <= n_cnt;
            r_acc    <= n_acc;
            r_pbi    <= n_pbi;
            r_dx     <= n_dx;
            r_halted <= n_halted;
            r_code   <= n_code;
        end
    end

`ifndef ASSERT_OFF
    a_halt_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> (r_code == rtfd_pkg::ST_EOB || r_code == rtfd_pkg::ST_BOUNDS))
        else $error("halted with no stop reason");

    a_rd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd <= r_len)
        else $error("read position ran past chunk length");

    a_halt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted && !(proc && r_in.start_of_chunk) |=> r_halted && $stable(r_out))
        else $error("halted parser changed position");
`endif

endmodule

`default_nettype wire

// ===== sv/rtfd_outq.sv =====
`default_nettype none

module rtfd_outq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rtfd_pkg::t_push    i_push,
    output logic                    o_room,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output rtfd_pkg::t_out          o_out_data
);

    rtfd_pkg::t_out r_slot [4];
    logic [1:0]     r_wr;
    logic [1:0]     r_rd;
    logic [2:0]     r_cnt;
    logic [2:0]     n_cnt;
    logic [1:0]     fin_idx;
    logic [1:0]     push_n;
    logic           pop;
    rtfd_pkg::t_out fin_word;

    assign o_room      = (r_cnt <= 3'd2);
    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out_data  = r_slot[r_rd];
    assign pop         = o_out_valid & i_out_ready;
    assign push_n      = {1'b0, i_push.span_vld} + {1'b0, i_push.fin_vld};
    assign fin_idx     = r_wr + {1'b0, i_push.span_vld};
    assign n_cnt       = r_cnt + {1'b0, push_n} - {2'b00, pop};

    // Finish word carries only its status
    always_comb begin
        fin_word            = '0;
        fin_word.kind       = rtfd_pkg::KIND_FINISH;
        fin_word.end_status = i_push.fin_status;
    end

    // Slot writes: span first, finish after it
    always_ff @(posedge i_clk) begin
        if (i_push.span_vld) begin
            r_slot[r_wr] <= i_push.span;
        end
        if (i_push.fin_vld) begin
            r_slot[fin_idx] <= fin_word;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wr  <= r_wr + push_n;
            r_rd  <= r_rd + {1'b0, pop};
            r_cnt <= n_cnt;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.span_vld || i_push.fin_vld) |-> r_cnt <= 3'd2)
        else $error("result queue pushed without room");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4 && r_wr == r_rd + r_cnt[1:0])
        else $error("result queue count and pointers disagree");
`endif

endmodule

`default_nettype wire

// ===== sv/rle_truecolor_frame_decoder.sv =====
`default_nettype none
// Run-length coded 24/32-bit frame decoder.
// Input channel (i_in_valid/o_in_ready/i_in_data) takes one coded byte per word;
// start_of_chunk marks a chunk's first byte and carries its length.
// Output channel (o_out_valid/i_out_ready/o_out_data) gives fill spans
// (offset, count, pixel) and, on a chunk's last byte, a finish word with status.
// Configuration (bytes per pixel, line width, frame size) is written over the
// APB port at byte addresses 0, 4 and 8; the user must write it only while the
// decoder is idle, as the block itself does not enforce this.
// A word accepted into the input register is parsed from there when the result
// queue has room; its results go to the result queue and are offered from there.
// Throughput: one byte per cycle while the result queue has room. A byte
// gives at most two results; the four-entry result queue drains one per cycle
// and the input register holds while more than two results are queued, so a
// stalled receiver backs up into o_in_ready within a couple of words.
// Reset (i_rst_n low, synchronous) loads the default configuration, empties the
// queue and the input register, and ignores bytes until the first chunk start.
module rle_truecolor_frame_decoder #(
    parameter int unsigned MAX_LINE_PIXELS = 4096,
    parameter int unsigned MAX_FRAME_BYTES = 16777216
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire rtfd_pkg::t_in      i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output rtfd_pkg::t_out          o_out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    rtfd_pkg::t_cfg  cfg;
    rtfd_pkg::t_push push;
    logic            room;

    rtfd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rtfd_parse #(
        .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_room     (room),
        .o_push     (push)
    );

    rtfd_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== tb/rle_truecolor_frame_decoder_tb.sv =====
`default_nettype none

module rle_truecolor_frame_decoder_tb;

    localparam int unsigned LINE_LIMIT    = 4096;
    localparam int unsigned FRAME_LIMIT   = 16777216;
    localparam longint unsigned POS_SAT   = 64'h7FF_FFFF;
    localparam int WATCHDOG_CYCLES        = 4000;
    localparam int SETTLE_CYCLES          = 8;
    localparam int PHASE_WORDS            = 60;
    localparam int MAX_PRINTED            = 40;

    // Coded stream bytes
    localparam logic [7:0] OP_ESCAPE = 8'h00;
    localparam logic [7:0] ESC_EOL   = 8'h00;
    localparam logic [7:0] ESC_EOB   = 8'h01;
    localparam logic [7:0] ESC_DELTA = 8'h02;

    localparam logic [1:0] REG_LIST [3] =
        '{rtfd_pkg::REG_BPP, rtfd_pkg::REG_LINE, rtfd_pkg::REG_FRAME};

    // Register settings per random phase, extremes and out-of-range values included
    localparam int NUM_SETTINGS = 8;
    localparam int unsigned SET_BPP [NUM_SETTINGS] = '{4, 3, 7, 0, 4, 5, 3, 4};
    localparam int unsigned SET_LINE [NUM_SETTINGS] = '{4096, 1, 8191, 0, 20, 100, 640, 2};
    localparam int unsigned SET_FRAME [NUM_SETTINGS] =
        '{16777216, 1, 33554431, 5000, 600, 300000, 921600, 16777215};

    typedef logic [7:0] t_code_bytes[$];

    // Expected span/finish words, computed from a private copy of the parser
    class span_scoreboard;
        logic [2:0]       cfg_bpp;
        logic [12:0]      cfg_line;
        logic [24:0]      cfg_frame;
        rtfd_pkg::t_phase phase;
        logic [24:0]      chunk_len;
        logic [24:0]      rd_pos;
        logic [26:0]      out_pos;
        logic [26:0]      line_pos;
        logic [7:0]       pix_left;
        logic [7:0]       skip_x;
        logic [31:0]      pix;
        logic [1:0]       pix_idx;
        logic [1:0]       halt_code;
        bit               halted;
        rtfd_pkg::t_out   expected_q[$];
        int               errors;

        function new();
            cfg_bpp   = rtfd_pkg::RST_BPP;
            cfg_line  = rtfd_pkg::RST_LINE;
            cfg_frame = rtfd_pkg::RST_FRAME;
            chunk_len = '0;
            errors    = 0;
            clear_chunk();
        endfunction

        function longint unsigned eff_bpp();
            return (cfg_bpp == 3'd4) ? 64'd4 : 64'd3;
        endfunction

        function longint unsigned eff_line();
            return (cfg_line > LINE_LIMIT) ? LINE_LIMIT : cfg_line;
        endfunction

        function longint unsigned eff_frame();
            return (cfg_frame > FRAME_LIMIT) ? FRAME_LIMIT : cfg_frame;
        endfunction

        function logic [26:0] sat27(longint unsigned v);
            return (v > POS_SAT) ? POS_SAT[26:0] : v[26:0];
        endfunction

        function void clear_chunk();
            phase     = rtfd_pkg::PH_OPCODE;
            rd_pos    = '0;
            out_pos   = '0;
            line_pos  = sat27(eff_bpp() * eff_line());
            pix_left  = '0;
            pix       = '0;
            pix_idx   = '0;
            skip_x    = '0;
            halted    = 1'b0;
            halt_code = rtfd_pkg::ST_EXHAUSTED;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                rtfd_pkg::REG_BPP:   cfg_bpp   = val[2:0];
                rtfd_pkg::REG_LINE:  cfg_line  = val[12:0];
                rtfd_pkg::REG_FRAME: cfg_frame = val[24:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [1:0] idx);
            case (idx)
                rtfd_pkg::REG_BPP:   return {29'd0, cfg_bpp};
                rtfd_pkg::REG_LINE:  return {19'd0, cfg_line};
                rtfd_pkg::REG_FRAME: return {7'd0, cfg_frame};
                default:             return '0;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void stop(logic [1:0] code);
            halted    = 1'b1;
            halt_code = code;
        endfunction

        // Gather one pixel byte; true once the pixel is whole
        function bit take_byte(logic [7:0] b, longint unsigned bpp);
            logic [1:0] idx;
            idx     = pix_idx;
            pix     = pix | ({24'd0, b} << (8 * idx));
            pix_idx = idx + 2'd1;
            return (idx + 1) == bpp;
        endfunction

        function void push_word(logic kind, logic [7:0] count, logic [1:0] status);
            rtfd_pkg::t_out w;
            w.kind         = kind;
            w.write_offset = (kind == rtfd_pkg::KIND_SPAN) ? out_pos[23:0] : 24'd0;
            w.pixel_count  = count;
            w.pixel_value  = (kind == rtfd_pkg::KIND_SPAN) ? pix : 32'd0;
            w.end_status   = status;
            expected_q.push_back(w);
        endfunction

        // Advance the parser by one accepted input word
        function void note_input(rtfd_pkg::t_in w);
            longint unsigned bpp, fb, lb, after, b, span;
            bpp  = eff_bpp();
            fb   = eff_frame();
            lb   = bpp * eff_line();
            b    = w.data_byte;
            span = b * bpp;
            if (w.start_of_chunk) begin
                chunk_len = w.chunk_length;
                clear_chunk();
            end
            if (rd_pos >= chunk_len) return;
            after = chunk_len - rd_pos - 1;

            if (!halted) begin
                case (phase)
                    rtfd_pkg::PH_ESCAPE: begin
                        if (w.data_byte == ESC_EOL) begin
                            out_pos  = line_pos;
                            line_pos = sat27(out_pos + lb);
                            phase    = rtfd_pkg::PH_OPCODE;
                        end else if (w.data_byte == ESC_EOB) begin
                            stop(rtfd_pkg::ST_EOB);
                        end else if (w.data_byte == ESC_DELTA) begin
                            if (after < 2) stop(rtfd_pkg::ST_BOUNDS);
                            else phase = rtfd_pkg::PH_DX;
                        end else if (after < span || out_pos + span > fb) begin
                            stop(rtfd_pkg::ST_BOUNDS);
                        end else begin
                            pix_left = w.data_byte;
                            pix      = '0;
                            pix_idx  = '0;
                            phase    = rtfd_pkg::PH_LIT;
                        end
                    end
                    rtfd_pkg::PH_RUN: begin
                        if (take_byte(w.data_byte, bpp)) begin
                            push_word(rtfd_pkg::KIND_SPAN, pix_left, rtfd_pkg::ST_EXHAUSTED);
                            out_pos = sat27(out_pos + pix_left * bpp);
                            phase   = rtfd_pkg::PH_OPCODE;
                        end
                    end
                    rtfd_pkg::PH_DX: begin
                        skip_x = w.data_byte;
                        phase  = rtfd_pkg::PH_DY;
                    end
                    rtfd_pkg::PH_DY: begin
                        out_pos  = sat27(out_pos + bpp * skip_x + b * lb);
                        line_pos = sat27(line_pos + b * lb);
                        phase    = rtfd_pkg::PH_OPCODE;
                    end
                    rtfd_pkg::PH_LIT: begin
                        if (take_byte(w.data_byte, bpp)) begin
                            push_word(rtfd_pkg::KIND_SPAN, 8'd1, rtfd_pkg::ST_EXHAUSTED);
                            out_pos  = sat27(out_pos + bpp);
                            pix      = '0;
                            pix_idx  = '0;
                            pix_left = pix_left - 8'd1;
                            if (pix_left == 8'd0) phase = rtfd_pkg::PH_OPCODE;
                        end
                    end
                    default: begin
                        if (out_pos >= fb || after < 1) begin
                            stop(rtfd_pkg::ST_BOUNDS);
                        end else if (w.data_byte == OP_ESCAPE) begin
                            phase = rtfd_pkg::PH_ESCAPE;
                        end else if (after < bpp || out_pos + span > fb) begin
                            stop(rtfd_pkg::ST_BOUNDS);
                        end else begin
                            pix_left = w.data_byte;
                            pix      = '0;
                            pix_idx  = '0;
                            phase    = rtfd_pkg::PH_RUN;
                        end
                    end
                endcase
            end

            // Last byte of the chunk closes it with a finish word
            if (after == 0)
                push_word(rtfd_pkg::KIND_FINISH, 8'd0,
                          halted ? halt_code : rtfd_pkg::ST_EXHAUSTED);
            rd_pos = rd_pos + 25'd1;
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED) $display("mismatch: %s", msg);
        endtask

        // Compare an accepted result word with the oldest expected one
        task check_result(rtfd_pkg::t_out got);
            rtfd_pkg::t_out want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result word %h with none expected", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.write_offset !== want.write_offset)
                report_mismatch($sformatf("write_offset %h, want %h",
                                          got.write_offset, want.write_offset));
            if (got.pixel_count !== want.pixel_count)
                report_mismatch($sformatf("pixel_count %0d, want %0d",
                                          got.pixel_count, want.pixel_count));
            if (got.pixel_value !== want.pixel_value)
                report_mismatch($sformatf("pixel_value %h, want %h",
                                          got.pixel_value, want.pixel_value));
            if (got.end_status !== want.end_status)
                report_mismatch($sformatf("end_status %0d, want %0d",
                                          got.end_status, want.end_status));
        endtask
    endclass

    logic           i_clk     = 1'b0;
    logic           i_rst_n   = 1'b0;
    logic           in_valid  = 1'b0;
    rtfd_pkg::t_in  in_data   = '0;
    logic           out_ready = 1'b0;
    logic           psel      = 1'b0;
    logic           penable   = 1'b0;
    logic           pwrite    = 1'b0;
    logic [3:0]     paddr     = '0;
    logic [31:0]    pwdata    = '0;
    logic           o_in_ready;
    logic           o_out_valid;
    rtfd_pkg::t_out o_out_data;
    logic [31:0]    prdata;
    logic           pready;

    bit          calm = 1'b0;
    int          idle_cycles = 0;

    span_scoreboard sb = new();

    rle_truecolor_frame_decoder #(
        .MAX_LINE_PIXELS(LINE_LIMIT),
        .MAX_FRAME_BYTES(FRAME_LIMIT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data(o_out_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // Gap length: mostly short, now and then long, none while calm
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side: random stalls on i_out_ready
    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                out_ready = 1'b0;
                stall--;
            end else begin
                out_ready = 1'b1;
                if ($urandom_range(0, 2) == 0) stall = pick_gap();
            end
        end
    end

    // Check every accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) sb.check_result(o_out_data);
    end

    // No progress while work is outstanding ends the run
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (!in_valid && sb.pending() == 0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("watchdog: no word moved for %0d cycles", idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Present one input word, hold until accepted; returns at a falling edge
    task automatic send_word(input rtfd_pkg::t_in w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = w;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(w);
        @(negedge i_clk);
    endtask

    task automatic send_chunk(ref t_code_bytes q, input logic [24:0] len);
        rtfd_pkg::t_in w;
        foreach (q[i]) begin
            w.data_byte      = q[i];
            w.start_of_chunk = (i == 0);
            w.chunk_length   = (i == 0) ? len : 25'($urandom);
            send_word(w);
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        paddr   = {idx, 2'b00};
        pwdata  = val;
        pwrite  = 1'b1;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(input logic [1:0] idx, output logic [31:0] val);
        paddr   = {idx, 2'b00};
        pwrite  = 1'b0;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        val = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Read back every register against the scoreboard copy
    task automatic check_regs();
        logic [31:0] got;
        foreach (REG_LIST[i]) begin
            apb_read(REG_LIST[i], got);
            if (got !== sb.reg_value(REG_LIST[i]))
                sb.report_mismatch($sformatf("register %0d reads %h, want %h",
                                             REG_LIST[i], got, sb.reg_value(REG_LIST[i])));
        end
    endtask

    task automatic set_config(input logic [31:0] bpp, line, frame);
        apb_write(rtfd_pkg::REG_BPP, bpp);
        sb.set_reg(rtfd_pkg::REG_BPP, bpp);
        apb_write(rtfd_pkg::REG_LINE, line);
        sb.set_reg(rtfd_pkg::REG_LINE, line);
        apb_write(rtfd_pkg::REG_FRAME, frame);
        sb.set_reg(rtfd_pkg::REG_FRAME, frame);
        check_regs();
    endtask

    // Stop sending, wait for every expected word, then let the pipe settle
    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Well-formed code sequence with random content
    function automatic void build_chunk(ref t_code_bytes q, input int bpp, input bit far,
                                        input bit eob);
        int nops, n, r;
        nops = far ? 45 : $urandom_range(1, 10);
        for (int k = 0; k < nops; k++) begin
            if (far) r = ($urandom_range(0, 9) == 0) ? 70 : 90;
            else r = $urandom_range(0, 99);
            if (r < 40) begin
                // run of one pixel
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 255)
                                                : $urandom_range(1, 12);
                q.push_back(8'(n));
                repeat (bpp) q.push_back(8'($urandom));
            end else if (r < 65) begin
                // literal block
                n = ($urandom_range(0, 6) == 0) ? $urandom_range(7, 20) : $urandom_range(3, 6);
                q.push_back(OP_ESCAPE);
                q.push_back(8'(n));
                repeat (n * bpp) q.push_back(8'($urandom));
            end else if (r < 80) begin
                q.push_back(OP_ESCAPE);
                q.push_back(ESC_EOL);
            end else begin
                // delta; far chunks push positions toward saturation
                q.push_back(OP_ESCAPE);
                q.push_back(ESC_DELTA);
                q.push_back(8'($urandom));
                if (far) q.push_back(8'hFF);
                else if ($urandom_range(0, 4) == 0) q.push_back(8'($urandom));
                else q.push_back(8'($urandom_range(0, 2)));
            end
        end
        if (eob) begin
            q.push_back(OP_ESCAPE);
            q.push_back(ESC_EOB);
        end
    endfunction

    task automatic directed_part();
        t_code_bytes q;
        rtfd_pkg::t_in w;
        // A byte before any chunk start is dropped
        w.data_byte      = 8'hFF;
        w.start_of_chunk = 1'b0;
        w.chunk_length   = 25'h1FF_FFFF;
        send_word(w);
        // Zero-length chunk drops its byte
        q = '{8'h00};
        send_chunk(q, 25'd0);
        // One-byte chunk has no room for a code: bounds stop
        q = '{8'h01};
        send_chunk(q, 25'd1);
        // Longest run, end of line, delta, literal block, end of bitmap
        q = '{8'hFF, 8'hFF, 8'h00, 8'h80, OP_ESCAPE, ESC_EOL,
              OP_ESCAPE, ESC_DELTA, 8'h05, 8'h01,
              OP_ESCAPE, 8'h03, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
              8'h12, 8'h34, 8'h56,
              OP_ESCAPE, ESC_EOB};
        send_chunk(q, 25'(q.size()));
    endtask

    // Mostly well-formed chunks, plus short, long, noisy and tiny ones
    task automatic random_phase(input int target, input bit open_far);
        t_code_bytes q;
        int count, r, sz;
        logic [24:0] len;
        bit eob, far;
        count = 0;
        while (count < target) begin
            q.delete();
            calm = ($urandom_range(0, 5) == 0);
            r    = $urandom_range(0, 99);
            eob  = $urandom_range(0, 1);
            far  = (count == 0 && open_far) || (r >= 60 && r < 63);
            if (r < 88) begin
                build_chunk(q, int'(sb.eff_bpp()), far, eob);
            end else begin
                repeat ((r < 96) ? $urandom_range(1, 30) : $urandom_range(1, 3))
                    q.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3))
                                                            : 8'($urandom));
            end
            sz = q.size();
            if (r < 66) begin
                len = 25'(sz);
                // bytes after the end code, inside or past the chunk
                if (eob && $urandom_range(0, 2) == 0) begin
                    repeat ($urandom_range(1, 3)) q.push_back(8'($urandom));
                    if ($urandom_range(0, 1) == 1) len = 25'(q.size());
                end
            end else if (r < 76) begin
                len = 25'(sz - $urandom_range(1, (sz > 6) ? 6 : sz));
            end else if (r < 82) begin
                len = 25'(sz + $urandom_range(1, 500));
            end else if (r < 88) begin
                len = ($urandom_range(0, 1) == 1) ? 25'h1FF_FFFF : {1'b1, 24'($urandom)};
            end else if (r < 96) begin
                len = 25'(sz);
            end else begin
                len = 25'($urandom_range(0, 2));
            end
            count += (len < q.size()) ? int'(len) : q.size();
            send_chunk(q, len);
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        check_regs();
        directed_part();
        drain();
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            set_config(SET_BPP[p], SET_LINE[p], SET_FRAME[p]);
            random_phase(PHASE_WORDS, SET_LINE[p] >= LINE_LIMIT);
            drain();
        end
        if (sb.errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
